/* hw/rtl/assert_macros.svh */
// assertion macros included by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/bmhq_pkg.sv */
// types and constants of the binary max heap queue
`timescale 1ns / 1ps

package bmhq_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

endpackage

/* hw/rtl/bmhq_if.sv */
// valid/ready channel interfaces for request and response items
`timescale 1ns / 1ps

interface bmhq_req_if;
   import bmhq_pkg::*;

   logic     valid;
   logic     ready;
   logic     cmd;
   data_type value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bmhq_rsp_if #(
   parameter int CNT_W = 7
);
   import bmhq_pkg::*;

   logic             valid;
   logic             ready;
   data_type         top_value;
   data_type         removed_value;
   logic [CNT_W-1:0] count;
   logic             empty_flag;
   status_type       status;

   modport source (output valid, output top_value, output removed_value, output count,
                   output empty_flag, output status, input ready);
   modport sink   (input valid, input top_value, input removed_value, input count,
                   input empty_flag, input status, output ready);
endinterface

/* hw/rtl/bmhq_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/binary_max_heap_queue_top.sv */
// Binary max heap priority queue; push sifts up, pop sifts down, one result per item.
// A push climbs while its parent is smaller and stops at the root; a pop moves the last
// entry to the root and sifts it down while a child is larger, stopping at a leaf; a dropped
// push, an empty pop or a pop of the last entry goes straight to the result.
// One item in work at a time; the next is taken the cycle after its result loads.
// Reset (synchronous) clears the state, the entry count and the result valid; the heap ram is not cleared.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module binary_max_heap_queue_top #(
   parameter int CAPACITY = 64
) (
   input  logic         clock,
   input  logic         reset,
   bmhq_req_if.sink     req_ch,
   bmhq_rsp_if.source   rsp_ch
);
   import bmhq_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CH_W  = IDX_W + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_RD_L,
      S_DN_RD_R,
      S_DN_CMP,
      S_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;
   data_type         hold_ff;
   data_type         left_ff;
   logic             right_ok_ff;
   data_type         root_ff;
   data_type         removed_ff;
   status_type       status_ff;

   logic             rsp_valid_ff;
   data_type         rsp_top_ff;
   data_type         rsp_removed_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_empty_ff;
   status_type       rsp_status_ff;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   data_type         ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   data_type         ram_rd_data;

   logic             req_fire;
   logic             rsp_free;
   logic [CH_W-1:0]  left_idx;
   logic [CH_W-1:0]  right_idx;
   logic [CH_W-1:0]  count_ext;
   logic [IDX_W-1:0] parent_idx;
   logic [IDX_W-1:0] last_idx;
   logic             pick_right;
   logic [IDX_W-1:0] child_idx;
   data_type         child_val;

   bmhq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshake
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // heap index arithmetic
   assign left_idx   = CH_W'({idx_ff, 1'b1});
   assign right_idx  = left_idx + CH_W'(1);
   assign count_ext  = CH_W'(count_ff);
   assign parent_idx = IDX_W'((idx_ff - IDX_W'(1)) >> 1);
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));

   // larger child, left wins a tie
   assign pick_right = right_ok_ff && (ram_rd_data > left_ff);
   assign child_idx  = pick_right ? IDX_W'(right_idx) : IDX_W'(left_idx);
   assign child_val  = pick_right ? ram_rd_data : left_ff;

   // ram port control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = hold_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = parent_idx;
      unique case (state_ff)
         S_IDLE: begin
            ram_rd_en   = req_fire && (req_ch.cmd == CMD_POP) && (count_ff > CNT_W'(1));
            ram_rd_addr = last_idx;
         end
         S_UP_RD: begin
            ram_wr_en = (idx_ff == '0);
            ram_rd_en = (idx_ff != '0);
         end
         S_UP_CMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data < hold_ff) begin
               ram_wr_data = ram_rd_data;
            end
         end
         S_DN_RD_L: begin
            ram_wr_en   = (left_idx >= count_ext);
            ram_rd_en   = (left_idx < count_ext);
            ram_rd_addr = IDX_W'(left_idx);
         end
         S_DN_RD_R: begin
            ram_rd_en   = (right_idx < count_ext);
            ram_rd_addr = IDX_W'(right_idx);
         end
         S_DN_CMP: begin
            ram_wr_en = 1'b1;
            if (child_val > hold_ff) begin
               ram_wr_data = child_val;
            end
         end
         S_DN_LAST, S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // sequencer, heap state and result registers
   always_ff @(posedge clock) begin
      // track the root on every write to entry zero
      if (ram_wr_en && (ram_wr_addr == '0)) begin
         root_ff <= ram_wr_data;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result taken; a load in S_DONE sets it again
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_ch.cmd == CMD_PUSH) begin
                     removed_ff <= '0;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_ff <= STS_FULL;
                        state_ff  <= S_DONE;
                     end else begin
                        status_ff <= STS_OK;
                        hold_ff   <= req_ch.value;
                        idx_ff    <= count_ff[IDX_W-1:0];
                        count_ff  <= count_ff + CNT_W'(1);
                        state_ff  <= S_UP_RD;
                     end
                  end else begin
                     if (count_ff == '0) begin
                        removed_ff <= '0;
                        status_ff  <= STS_EMPTY;
                        state_ff   <= S_DONE;
                     end else begin
                        removed_ff <= root_ff;
                        status_ff  <= STS_OK;
                        count_ff   <= count_ff - CNT_W'(1);
                        state_ff   <= (count_ff == CNT_W'(1)) ? S_DONE : S_DN_LAST;
                     end
                  end
               end
            end
            S_UP_RD: begin
               state_ff <= (idx_ff == '0) ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
               if (ram_rd_data < hold_ff) begin
                  idx_ff   <= parent_idx;
                  state_ff <= S_UP_RD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DN_LAST: begin
               hold_ff  <= ram_rd_data;
               idx_ff   <= '0;
               state_ff <= S_DN_RD_L;
            end
            S_DN_RD_L: begin
               state_ff <= (left_idx >= count_ext) ? S_DONE : S_DN_RD_R;
            end
            S_DN_RD_R: begin
               left_ff     <= ram_rd_data;
               right_ok_ff <= (right_idx < count_ext);
               state_ff    <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (child_val > hold_ff) begin
                  idx_ff   <= child_idx;
                  state_ff <= S_DN_RD_L;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_top_ff     <= (count_ff == '0) ? data_type'(0) : root_ff;
                  rsp_removed_ff <= removed_ff;
                  rsp_count_ff   <= count_ff;
                  rsp_empty_ff   <= (count_ff == '0);
                  rsp_status_ff  <= status_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // response channel
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.top_value     = rsp_top_ff;
   assign rsp_ch.removed_value = rsp_removed_ff;
   assign rsp_ch.count         = rsp_count_ff;
   assign rsp_ch.empty_flag    = rsp_empty_ff;
   assign rsp_ch.status        = rsp_status_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `ASSERT_IMPL(a_write_in_range, clock, reset, ram_wr_en, CH_W'(ram_wr_addr) < count_ext, "heap write beyond count")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ch.ready, "item accepted while busy")
   `ASSERT_IMPL(a_empty_matches_count, clock, reset, rsp_valid_ff, rsp_empty_ff == (rsp_count_ff == '0), "empty flag mismatch")

endmodule
